// ===== hw/rtl/hbi_pkg.sv =====
package hbi_pkg;

    localparam int HBI_KEY_BYTES    = 8;
    localparam int HBI_LOG_BUCKETS  = 10;
    localparam int HBI_BUCKET_DEPTH = 16;
    localparam int HBI_REPEAT_DEPTH = 64;

    localparam int KEY_W      = 64;
    localparam int OFFSET_W   = 32;
    localparam int SLOT_W     = 6;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 7;
    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 4;
    localparam int WORD_STEP  = 3;
    localparam int NUM_REPEAT = 256;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic count_rd;
        logic count_wr;
        logic entry_rd;
        logic entry_wr;
        logic same_bytes;
    } tbl_ctrl_t;

endpackage

// ===== hw/rtl/hbi_hash.sv =====
module hbi_hash
    import hbi_pkg::*;
#(
    parameter int KEY_BYTES   = HBI_KEY_BYTES,
    parameter int LOG_BUCKETS = HBI_LOG_BUCKETS
)
(
    input  logic [KEY_W-1:0]       key,
    output logic                   same_bytes,
    output logic [BYTE_W-1:0]      lead_byte,
    output logic [LOG_BUCKETS-1:0] hashed_idx
);

    assign lead_byte = key[BYTE_W-1:0];

    // only the low LOG_BUCKETS bits of each word reach the masked sum
    always_comb
    begin
        same_bytes = 1'b1;
        for (int i = 1; i < KEY_BYTES; i++)
        begin
            if (key[BYTE_W*i +: BYTE_W] != key[BYTE_W-1:0])
            begin
                same_bytes = 1'b0;
            end
        end
        hashed_idx = '0;
        for (int i = 0; i + WORD_BYTES <= KEY_BYTES; i += WORD_STEP)
        begin
            hashed_idx = hashed_idx + key[BYTE_W*i +: LOG_BUCKETS];
        end
        hashed_idx = hashed_idx + key[BYTE_W*(KEY_BYTES-WORD_BYTES) +: LOG_BUCKETS];
    end

endmodule

// ===== hw/rtl/hbi_table.sv =====
module hbi_table
    import hbi_pkg::*;
#(
    parameter int LOG_BUCKETS  = HBI_LOG_BUCKETS,
    parameter int BUCKET_DEPTH = HBI_BUCKET_DEPTH,
    parameter int REPEAT_DEPTH = HBI_REPEAT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tbl_ctrl_t              ctrl,
    input  logic [LOG_BUCKETS-1:0] h_idx,
    input  logic [BYTE_W-1:0]      r_idx,
    input  logic [SLOT_W-1:0]      pos,
    input  logic [COUNT_W-1:0]     cnt_wdata,
    input  logic [OFFSET_W-1:0]    ent_wdata,
    output logic                   busy,
    output logic [COUNT_W-1:0]     h_count,
    output logic [COUNT_W-1:0]     r_count,
    output logic [OFFSET_W-1:0]    entry_rdata
);

    localparam int HCW   = $clog2(BUCKET_DEPTH + 1);
    localparam int RCW   = $clog2(REPEAT_DEPTH + 1);
    localparam int HSW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int RSW   = (REPEAT_DEPTH > 1) ? $clog2(REPEAT_DEPTH) : 1;
    localparam int CLR_W = (LOG_BUCKETS > BYTE_W) ? LOG_BUCKETS : BYTE_W;

    logic [HCW-1:0]      hashed_counts_mem  [2**LOG_BUCKETS];
    logic [RCW-1:0]      repeat_counts_mem  [NUM_REPEAT];
    logic [OFFSET_W-1:0] hashed_entries_mem [2**(LOG_BUCKETS+HSW)];
    logic [OFFSET_W-1:0] repeat_entries_mem [NUM_REPEAT*(2**RSW)];

    logic                clr_busy_reg;
    logic [CLR_W-1:0]    clr_addr_reg;
    logic [HCW-1:0]      h_cnt_reg;
    logic [RCW-1:0]      r_cnt_reg;
    logic [OFFSET_W-1:0] h_ent_reg;
    logic [OFFSET_W-1:0] r_ent_reg;
    logic                ent_sel_reg;

    logic [LOG_BUCKETS+HSW-1:0] h_ent_addr;
    logic [BYTE_W+RSW-1:0]      r_ent_addr;

    assign h_ent_addr = {h_idx, pos[HSW-1:0]};
    assign r_ent_addr = {r_idx, pos[RSW-1:0]};

    // count stores swept to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            hashed_counts_mem[clr_addr_reg[LOG_BUCKETS-1:0]] <= '0;
        end
        else if (ctrl.count_wr && !ctrl.same_bytes)
        begin
            hashed_counts_mem[h_idx] <= HCW'(cnt_wdata);
        end
        if (ctrl.count_rd)
        begin
            h_cnt_reg <= hashed_counts_mem[h_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            repeat_counts_mem[clr_addr_reg[BYTE_W-1:0]] <= '0;
        end
        else if (ctrl.count_wr && ctrl.same_bytes)
        begin
            repeat_counts_mem[r_idx] <= RCW'(cnt_wdata);
        end
        if (ctrl.count_rd)
        begin
            r_cnt_reg <= repeat_counts_mem[r_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.entry_wr && !ctrl.same_bytes)
        begin
            hashed_entries_mem[h_ent_addr] <= ent_wdata;
        end
        if (ctrl.entry_rd)
        begin
            h_ent_reg <= hashed_entries_mem[h_ent_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.entry_wr && ctrl.same_bytes)
        begin
            repeat_entries_mem[r_ent_addr] <= ent_wdata;
        end
        if (ctrl.entry_rd)
        begin
            r_ent_reg   <= repeat_entries_mem[r_ent_addr];
            ent_sel_reg <= ctrl.same_bytes;
        end
    end

    assign busy        = clr_busy_reg;
    assign h_count     = COUNT_W'(h_cnt_reg);
    assign r_count     = COUNT_W'(r_cnt_reg);
    assign entry_rdata = ent_sel_reg ? r_ent_reg : h_ent_reg;

endmodule

// ===== hw/rtl/block_hash_bucket_insert_core.sv =====
// Bucketed hash table: each transfer on the item channel inserts an offset
// under a key, or reads one slot of the key's bucket, and gives exactly one
// transfer on the result channel. Keys whose bytes are all equal go to one of
// 256 one-character buckets; others are hashed into 2**LOG_BUCKETS buckets.
// Items are handled one at a time: an insert, or a read of an empty slot,
// passes through the read of the count memory and the result load before
// the next possible transfer; a read that finds an entry also reads the
// entry memory. A result still waiting on result_ready holds the next one
// back until it is taken. After reset the count memories are swept to zero
// by stepping a clear address through max(2**LOG_BUCKETS, 256) values (1024
// by default); item_ready rises in the cycle after the sweep ends.
module block_hash_bucket_insert_core
    import hbi_pkg::*;
#(
    parameter int KEY_BYTES    = HBI_KEY_BYTES,
    parameter int LOG_BUCKETS  = HBI_LOG_BUCKETS,
    parameter int BUCKET_DEPTH = HBI_BUCKET_DEPTH,
    parameter int REPEAT_DEPTH = HBI_REPEAT_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                command,
    input  logic [KEY_W-1:0]    key,
    input  logic [OFFSET_W-1:0] offset,
    input  logic [SLOT_W-1:0]   slot,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [INDEX_W-1:0]  bucket_index,
    output logic                same_bytes,
    output logic [COUNT_W-1:0]  bucket_count,
    output logic [OFFSET_W-1:0] slot_data,
    output logic [1:0]          status,
    output logic [COUNT_W-1:0]  max_bucket
);

    typedef enum logic [4:0]
    {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_FETCH = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   one_reg, one_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [LOG_BUCKETS-1:0] hidx_reg, hidx_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    status_t                res_status_reg, res_status_next;
    logic [OFFSET_W-1:0]    res_data_reg, res_data_next;
    logic [COUNT_W-1:0]     largest_reg, largest_next;
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     out_index_reg, out_index_next;
    logic                   out_one_reg, out_one_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic [OFFSET_W-1:0]    out_data_reg, out_data_next;
    status_t                out_status_reg, out_status_next;
    logic [COUNT_W-1:0]     out_max_reg, out_max_next;

    logic                   key_one;
    logic [BYTE_W-1:0]      key_byte;
    logic [LOG_BUCKETS-1:0] key_hidx;

    tbl_ctrl_t              ctrl;
    logic [LOG_BUCKETS-1:0] tbl_h_idx;
    logic [BYTE_W-1:0]      tbl_r_idx;
    logic [SLOT_W-1:0]      tbl_pos;
    logic [COUNT_W-1:0]     tbl_cnt_wdata;
    logic                   tbl_busy;
    logic [COUNT_W-1:0]     tbl_h_count;
    logic [COUNT_W-1:0]     tbl_r_count;
    logic [OFFSET_W-1:0]    tbl_entry_rdata;

    logic [COUNT_W-1:0]             cur_count;
    logic [COUNT_W-1:0]             inc_count;
    logic [COUNT_W-1:0]             depth;
    logic [COUNT_W-1:0]             slot_ext;
    logic [LOG_BUCKETS+INDEX_W-1:0] hidx_wide;

    hbi_hash #(
        .KEY_BYTES   (KEY_BYTES),
        .LOG_BUCKETS (LOG_BUCKETS)
    ) u_hash (
        .key        (key),
        .same_bytes (key_one),
        .lead_byte  (key_byte),
        .hashed_idx (key_hidx)
    );

    hbi_table #(
        .LOG_BUCKETS  (LOG_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .REPEAT_DEPTH (REPEAT_DEPTH)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .h_idx       (tbl_h_idx),
        .r_idx       (tbl_r_idx),
        .pos         (tbl_pos),
        .cnt_wdata   (tbl_cnt_wdata),
        .ent_wdata   (offset_reg),
        .busy        (tbl_busy),
        .h_count     (tbl_h_count),
        .r_count     (tbl_r_count),
        .entry_rdata (tbl_entry_rdata)
    );

    assign item_ready = (state_reg == S_IDLE);

    assign cur_count = one_reg ? tbl_r_count : tbl_h_count;
    assign inc_count = cur_count + 1'b1;
    assign depth     = one_reg ? COUNT_W'(REPEAT_DEPTH) : COUNT_W'(BUCKET_DEPTH);
    assign slot_ext  = COUNT_W'(slot_reg);
    assign hidx_wide = {{INDEX_W{1'b0}}, hidx_reg};

    // count read is issued from the ports at the item transfer
    assign tbl_h_idx = (state_reg == S_IDLE) ? key_hidx : hidx_reg;
    assign tbl_r_idx = (state_reg == S_IDLE) ? key_byte : byte_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        offset_next     = offset_reg;
        slot_next       = slot_reg;
        one_next        = one_reg;
        byte_next       = byte_reg;
        hidx_next       = hidx_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        largest_next    = largest_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_index_next  = out_index_reg;
        out_one_next    = out_one_reg;
        out_count_next  = out_count_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_max_next    = out_max_reg;

        ctrl            = '0;
        ctrl.same_bytes = (state_reg == S_IDLE) ? key_one : one_reg;
        tbl_pos         = slot_reg;
        tbl_cnt_wdata   = inc_count;

        case (state_reg)
            S_CLEAR:
            begin
                if (!tbl_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.count_rd = 1'b1;
                    cmd_next      = cmd_t'(command);
                    offset_next   = offset;
                    slot_next     = slot;
                    one_next      = key_one;
                    byte_next     = key_byte;
                    hidx_next     = key_hidx;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_data_next  = '0;
                res_count_next = cur_count;
                state_next     = S_EMIT;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (cur_count >= depth)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.count_wr   = 1'b1;
                            ctrl.entry_wr   = 1'b1;
                            tbl_pos         = cur_count[SLOT_W-1:0];
                            res_count_next  = inc_count;
                            res_status_next = STATUS_OK;
                            if (inc_count > largest_reg)
                            begin
                                largest_next = inc_count;
                            end
                        end
                    end
                    CMD_READ:
                    begin
                        if (slot_ext < cur_count && slot_ext < depth)
                        begin
                            ctrl.entry_rd   = 1'b1;
                            res_status_next = STATUS_OK;
                            state_next      = S_FETCH;
                        end
                        else
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end
            S_FETCH:
            begin
                res_data_next = tbl_entry_rdata;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = one_reg ? INDEX_W'(byte_reg) : hidx_wide[INDEX_W-1:0];
                    out_one_next    = one_reg;
                    out_count_next  = res_count_reg;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    out_max_next    = largest_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            largest_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_one_reg    <= 1'b0;
            out_count_reg  <= '0;
            out_data_reg   <= '0;
            out_status_reg <= STATUS_OK;
            out_max_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            largest_reg    <= largest_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_one_reg    <= out_one_next;
            out_count_reg  <= out_count_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_max_reg    <= out_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        offset_reg     <= offset_next;
        slot_reg       <= slot_next;
        one_reg        <= one_next;
        byte_reg       <= byte_next;
        hidx_reg       <= hidx_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

    assign result_valid = out_valid_reg;
    assign bucket_index = out_index_reg;
    assign same_bytes   = out_one_reg;
    assign bucket_count = out_count_reg;
    assign slot_data    = out_data_reg;
    assign status       = out_status_reg;
    assign max_bucket   = out_max_reg;

endmodule

// ===== hw/rtl/hbi_checker.sv =====
module hbi_checker
    import hbi_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic [INDEX_W-1:0]  bucket_index,
    input logic                same_bytes,
    input logic [COUNT_W-1:0]  bucket_count,
    input logic [OFFSET_W-1:0] slot_data,
    input logic [1:0]          status,
    input logic [COUNT_W-1:0]  max_bucket
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(bucket_count)
            && $stable(slot_data) && $stable(status) && $stable(bucket_index)
            && $stable(same_bytes) && $stable(max_bucket))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while one in flight");

    a_count_within_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> bucket_count <= max_bucket)
        else $error("bucket count above largest count");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_bucket >= $past(max_bucket))
        else $error("largest count went down");

    a_no_data_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_FULL || status == STATUS_EMPTY) |-> slot_data == '0)
        else $error("data returned with error status");

endmodule

bind block_hash_bucket_insert_core hbi_checker u_hbi_checker (.*);

// ===== tb/sv/block_hash_bucket_insert_core_tb.sv =====
`timescale 1ns / 100ps

module block_hash_bucket_insert_core_tb;
    import hbi_pkg::*;

    localparam int NUM_HASHED = 1 << HBI_LOG_BUCKETS;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 175;

    typedef struct
    {
        cmd_t                cmd;
        logic [KEY_W-1:0]    key;
        logic [OFFSET_W-1:0] offset;
        logic [SLOT_W-1:0]   slot;
    } bucket_req_t;

    typedef struct
    {
        logic [INDEX_W-1:0]  index;
        logic                one;
        logic [COUNT_W-1:0]  count;
        logic [OFFSET_W-1:0] data;
        status_t             status;
        logic [COUNT_W-1:0]  max_count;
    } bucket_resp_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic                command      = 1'b0;
    logic [KEY_W-1:0]    key          = '0;
    logic [OFFSET_W-1:0] offset       = '0;
    logic [SLOT_W-1:0]   slot         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [INDEX_W-1:0]  bucket_index;
    logic                same_bytes;
    logic [COUNT_W-1:0]  bucket_count;
    logic [OFFSET_W-1:0] slot_data;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  max_bucket;

    bucket_req_t  pending_items[$];
    bucket_resp_t awaited_resp[$];
    logic         item_taken = 1'b0;
    int           send_idle  = 0;
    int           recv_stall = 0;
    int           mismatches = 0;

    // table mirror
    int unsigned hashed_cnt[NUM_HASHED];
    bit [31:0]   hashed_ent[NUM_HASHED][HBI_BUCKET_DEPTH];
    int unsigned repeat_cnt[NUM_REPEAT];
    bit [31:0]   repeat_ent[NUM_REPEAT][HBI_REPEAT_DEPTH];
    int unsigned largest_cnt = 0;

    logic [KEY_W-1:0] hot_keys[6];
    logic [7:0]       hot_bytes[3];

    block_hash_bucket_insert_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .key          (key),
        .offset       (offset),
        .slot         (slot),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .bucket_index (bucket_index),
        .same_bytes   (same_bytes),
        .bucket_count (bucket_count),
        .slot_data    (slot_data),
        .status       (status),
        .max_bucket   (max_bucket)
    );

    always #1 clk = ~clk;

    function automatic bucket_resp_t bucket_access(bucket_req_t req);
        bucket_resp_t resp;
        int unsigned  idx;
        int unsigned  cnt;
        int unsigned  depth;
        logic [31:0]  sum;
        logic         same;
        same = 1'b1;
        for (int i = 1; i < HBI_KEY_BYTES; i++)
        begin
            if (req.key[BYTE_W*i +: BYTE_W] != req.key[BYTE_W-1:0])
                same = 1'b0;
        end
        sum = '0;
        for (int i = 0; i + WORD_BYTES <= HBI_KEY_BYTES; i += WORD_STEP)
            sum += req.key[BYTE_W*i +: 32];
        sum += req.key[BYTE_W*(HBI_KEY_BYTES-WORD_BYTES) +: 32];
        if (same)
        begin
            idx   = 32'(req.key[BYTE_W-1:0]);
            cnt   = repeat_cnt[idx];
            depth = HBI_REPEAT_DEPTH;
        end
        else
        begin
            idx   = sum & (NUM_HASHED - 1);
            cnt   = hashed_cnt[idx];
            depth = HBI_BUCKET_DEPTH;
        end
        resp.data   = '0;
        resp.status = STATUS_OK;
        if (req.cmd == CMD_INSERT)
        begin
            if (cnt >= depth)
                resp.status = STATUS_FULL;
            else
            begin
                if (same)
                    repeat_ent[idx][cnt] = req.offset;
                else
                    hashed_ent[idx][cnt] = req.offset;
                cnt++;
                if (same)
                    repeat_cnt[idx] = cnt;
                else
                    hashed_cnt[idx] = cnt;
                if (cnt > largest_cnt)
                    largest_cnt = cnt;
            end
        end
        else if (req.slot < cnt && req.slot < depth)
            resp.data = same ? repeat_ent[idx][req.slot] : hashed_ent[idx][req.slot];
        else
            resp.status = STATUS_EMPTY;
        resp.index     = idx[INDEX_W-1:0];
        resp.one       = same;
        resp.count     = cnt[COUNT_W-1:0];
        resp.max_count = largest_cnt[COUNT_W-1:0];
        return resp;
    endfunction

    task automatic push_item(cmd_t cmd, logic [KEY_W-1:0] k, logic [OFFSET_W-1:0] ofs,
                             logic [SLOT_W-1:0] s);
        bucket_req_t req;
        req.cmd    = cmd;
        req.key    = k;
        req.offset = ofs;
        req.slot   = s;
        pending_items.push_back(req);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(99);
        if (r < 10)
            k = {$urandom, $urandom};
        else if (r < 20)
            k = {8{8'($urandom)}};
        else if (r < 30)
        begin
            // all bytes equal but one
            k = {8{8'($urandom)}};
            k[BYTE_W*$urandom_range(7) +: BYTE_W] = 8'($urandom);
        end
        else if (r < 70)
        begin
            // top bytes drop out of the masked sum, so these collide
            k = hot_keys[$urandom_range(5)];
            if ($urandom_range(1))
                k[63:48] = 16'($urandom);
        end
        else
            k = {8{hot_bytes[$urandom_range(2)]}};
        return k;
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || awaited_resp.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!item_valid || item_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                item_valid <= 1'b1;
                command    <= pending_items[0].cmd;
                key        <= pending_items[0].key;
                offset     <= pending_items[0].offset;
                slot       <= pending_items[0].slot;
                void'(pending_items.pop_front());
            end
            else
                item_valid <= 1'b0;
        end
        result_ready <= ($urandom_range(99) >= recv_stall);
    end

    // monitor: result check first, then predict for the input transfer
    always @(posedge clk)
    begin
        bucket_resp_t want;
        bucket_req_t  req;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (awaited_resp.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = awaited_resp.pop_front();
                    check_field("bucket_index", want.index, bucket_index);
                    check_field("same_bytes", want.one, same_bytes);
                    check_field("bucket_count", want.count, bucket_count);
                    check_field("slot_data", want.data, slot_data);
                    check_field("status", want.status, status);
                    check_field("max_bucket", want.max_count, max_bucket);
                end
            end
            if (item_valid && item_ready)
            begin
                req.cmd    = cmd_t'(command);
                req.key    = key;
                req.offset = offset;
                req.slot   = slot;
                awaited_resp.push_back(bucket_access(req));
            end
            item_taken <= item_valid && item_ready;
        end
    end

    initial
    begin
        int send_pct[4];
        int recv_pct[4];
        logic [KEY_W-1:0] hk;
        send_pct = '{0, 46, 0, 13};
        recv_pct = '{0, 0, 46, 13};
        hot_bytes[0] = 8'h00;
        hot_bytes[1] = 8'hFF;
        hot_bytes[2] = 8'($urandom);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        hk = 64'h0123_4567_89AB_CDEF;
        push_item(CMD_INSERT, '0, '0, '0);
        push_item(CMD_INSERT, '1, '1, '0);
        push_item(CMD_READ, '0, '0, 6'd0);
        push_item(CMD_READ, '1, '0, 6'd0);
        push_item(CMD_READ, '0, '1, 6'd1);
        push_item(CMD_READ, '1, '0, 6'd63);
        push_item(CMD_INSERT, hk, 32'h5A5A_A5A5, '1);
        push_item(CMD_INSERT, {8'h77, hk[55:0]}, 32'h8000_0001, '0);
        push_item(CMD_READ, hk, '0, 6'd0);
        push_item(CMD_READ, hk, '0, 6'd1);
        push_item(CMD_READ, hk, '0, 6'd2);
        push_item(CMD_READ, 64'hFEDC_BA98_7654_3210, '0, 6'd0);
        push_item(CMD_INSERT, 64'h0000_0000_0000_0001, 32'h1, '0);
        push_item(CMD_INSERT, 64'h0100_0000_0000_0000, 32'h2, '0);
        push_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h3, '0);
        push_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h4, '0);
        push_item(CMD_INSERT, 64'h8080_8080_8080_8080, 32'h7FFF_FFFF, '0);
        push_item(CMD_READ, 64'h8080_8080_8080_8080, '0, 6'd0);
        push_item(CMD_READ, 64'h0000_0000_0000_0001, '0, 6'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle = send_pct[p % 4];
            recv_stall = recv_pct[p % 4];
            hot_bytes[2] = 8'($urandom);
            for (int i = 0; i < 6; i++)
                hot_keys[i] = {$urandom, $urandom};
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                push_item(($urandom_range(99) < 65) ? CMD_INSERT : CMD_READ, pick_key(),
                          pick_offset(),
                          6'(($urandom_range(99) < 60) ? $urandom_range(17)
                                                       : $urandom_range(63)));
            end
            // sender holds off until the block has returned everything
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hbi_pkg.sv
hw/rtl/hbi_hash.sv
hw/rtl/hbi_table.sv
hw/rtl/block_hash_bucket_insert_core.sv
hw/rtl/hbi_checker.sv
tb/sv/block_hash_bucket_insert_core_tb.sv
